[rtl/multi_level_threshold_alarm_top_defines.svh]
// Assertion macros used by the threshold alarm checker.
`ifndef MULTI_LEVEL_THRESHOLD_ALARM_TOP_DEFINES_SVH
`define MULTI_LEVEL_THRESHOLD_ALARM_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MLTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MLTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mlta_pkg.sv]
// Shared types and constants of the multi-level threshold alarm.
package mlta_pkg;

    typedef enum logic [1:0] {
        LVL_CLEAR = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_CRIT  = 2'd2,
        LVL_EMERG = 2'd3
    } level_t;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd3;

    // Fixed low fields of the result tdata
    localparam int OUT_RULE_LSB   = 0;
    localparam int OUT_LEVEL_LSB  = 3;
    localparam int OUT_ACTIVE_BIT = 5;
    localparam int OUT_VALUE_LSB  = 6;

    typedef struct packed {
        level_t     level;
        logic [7:0] count;
    } status_t;

endpackage

[rtl/multi_level_threshold_alarm_top.sv]
// Multi-level threshold alarm with debounce: rule memories and evaluation pipeline.
// A result reaches m_axis from the evaluation stage through the output register.
// Throughput: one item per cycle unless m_axis stalls; set by the single status
// read-modify-write, closed by a one-deep write bypass on each memory.
// Reset: clears pipeline control, the status valid bits (level and count read
// as zero) and sets debounce_length to 3; thresholds are undefined until loaded.
module multi_level_threshold_alarm_top
    import mlta_pkg::*;
#(
    parameter int RULE_COUNT  = 8,
    parameter int VALUE_WIDTH = 32
)(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: debounce_length
    input  logic                   cfg_wr_en,
    input  logic [7:0]             cfg_wr_data,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: rule_index[3], sample_value, warn_limit, crit_limit, emerg_limit,
    //        side select[1], zero pad
    input  logic [((4*VALUE_WIDTH+4+7)/8)*8-1:0] s_axis_tdata,
    // tuser: mode[0], skip[1]
    input  logic [1:0]             s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: alert_rule[3], alert_level[2], alert_active[1], alert_value,
    //        alert_threshold, zero pad
    output logic [((2*VALUE_WIDTH+6+7)/8)*8-1:0] m_axis_tdata
);

    localparam int VW     = VALUE_WIDTH;
    localparam int ADDR_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int THR_W  = 3*VW + 1;
    localparam int OUT_W  = ((2*VW + 6 + 7) / 8) * 8;
    localparam logic [6:0] RULE_LIM = 7'(RULE_COUNT);

    // ------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------
    logic [2:0]        in_rule;
    logic [ADDR_W-1:0] in_addr;
    logic              in_hit;
    logic              in_accept;

    assign in_rule   = s_axis_tdata[2:0];
    assign in_addr   = ADDR_W'({3'b000, in_rule});
    assign in_hit    = ({4'd0, in_rule} < RULE_LIM);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [7:0]          debounce_length_reg;

    // evaluation stage (one item, memory read data arrives here)
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_mode_reg;
    logic                s1_skip_reg;
    logic                s1_hit_reg;
    logic [2:0]          s1_rule_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [VW-1:0]       s1_value_reg;
    logic [THR_W-1:0]    s1_load_reg;   // {side, emerg, crit, warn} of a load

    // memories and their read registers
    logic [THR_W-1:0]    thr_mem [RULE_COUNT];
    status_t             st_mem  [RULE_COUNT];
    logic [THR_W-1:0]    thr_rd_reg;
    status_t             st_rd_reg;
    logic [RULE_COUNT-1:0] st_vld_reg, st_vld_next;

    // last write to each memory, covers a read that crossed it
    logic                thr_byp_valid_reg;
    logic [ADDR_W-1:0]   thr_byp_addr_reg;
    logic [THR_W-1:0]    thr_byp_data_reg;
    logic                st_byp_valid_reg;
    logic [ADDR_W-1:0]   st_byp_addr_reg;
    status_t             st_byp_data_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg;

    // ------------------------------------------------------------------
    // Evaluation
    // ------------------------------------------------------------------
    logic [THR_W-1:0] thr_cur;
    status_t          st_cur;
    logic [VW-1:0]    warn_cur, crit_cur, emerg_cur;
    logic             side_cur;
    level_t           lvl;
    logic [7:0]       count_inc;
    logic             do_load, do_sample;
    logic             raise, clear, has_result;
    logic             out_free, s1_fire;
    logic             thr_wr, st_wr;
    status_t          st_wdata;
    logic [VW-1:0]    thr_sel;
    logic [OUT_W-1:0] out_data_next;

    assign thr_cur = (thr_byp_valid_reg && (thr_byp_addr_reg == s1_addr_reg))
                   ? thr_byp_data_reg : thr_rd_reg;

    always_comb
    begin
        if (st_byp_valid_reg && (st_byp_addr_reg == s1_addr_reg))
        begin
            st_cur = st_byp_data_reg;
        end
        else if (st_vld_reg[s1_addr_reg])
        begin
            st_cur = st_rd_reg;
        end
        else
        begin
            st_cur = '0;
        end
    end

    assign warn_cur  = thr_cur[0 +: VW];
    assign crit_cur  = thr_cur[VW +: VW];
    assign emerg_cur = thr_cur[2*VW +: VW];
    assign side_cur  = thr_cur[3*VW];

    // exact signed compares, highest level first
    always_comb
    begin
        if (side_cur)
        begin
            if      ($signed(s1_value_reg) > $signed(emerg_cur)) lvl = LVL_EMERG;
            else if ($signed(s1_value_reg) > $signed(crit_cur))  lvl = LVL_CRIT;
            else if ($signed(s1_value_reg) > $signed(warn_cur))  lvl = LVL_WARN;
            else                                                 lvl = LVL_CLEAR;
        end
        else
        begin
            if      ($signed(s1_value_reg) < $signed(emerg_cur)) lvl = LVL_EMERG;
            else if ($signed(s1_value_reg) < $signed(crit_cur))  lvl = LVL_CRIT;
            else if ($signed(s1_value_reg) < $signed(warn_cur))  lvl = LVL_WARN;
            else                                                 lvl = LVL_CLEAR;
        end
    end

    assign count_inc = (st_cur.count != COUNT_MAX) ? st_cur.count + 8'd1 : st_cur.count;

    assign do_load   = s1_valid_reg && s1_hit_reg && (s1_mode_reg == MODE_LOAD);
    assign do_sample = s1_valid_reg && s1_hit_reg && (s1_mode_reg == MODE_SAMPLE)
                    && !s1_skip_reg;

    assign raise      = (lvl != LVL_CLEAR) && (count_inc >= debounce_length_reg)
                     && (lvl != st_cur.level);
    assign clear      = (lvl == LVL_CLEAR) && (st_cur.level != LVL_CLEAR);
    assign has_result = do_sample && (raise || clear);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && (!has_result || out_free);
    assign s_axis_tready = !s1_valid_reg || s1_fire;

    assign thr_wr = s1_fire && do_load;
    assign st_wr  = s1_fire && (do_load || do_sample);

    always_comb
    begin
        st_wdata = '0;
        if (do_sample && (lvl != LVL_CLEAR))
        begin
            st_wdata.count = count_inc;
            st_wdata.level = raise ? lvl : st_cur.level;
        end
    end

    always_comb
    begin
        case (lvl)
            LVL_EMERG: thr_sel = emerg_cur;
            LVL_CRIT:  thr_sel = crit_cur;
            default:   thr_sel = warn_cur;   // warning, and the clear report
        endcase
    end

    assign out_data_next = OUT_W'({thr_sel, s1_value_reg, raise,
                                   (raise ? lvl : LVL_CLEAR), s1_rule_reg});

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (s1_fire && has_result)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        st_vld_next = st_vld_reg;
        if (st_wr)
        begin
            st_vld_next[s1_addr_reg] = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_length_reg <= DEBOUNCE_RESET;
            s1_valid_reg        <= 1'b0;
            m_valid_reg         <= 1'b0;
            st_vld_reg          <= '0;
            thr_byp_valid_reg   <= 1'b0;
            st_byp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                debounce_length_reg <= cfg_wr_data;
            end
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            st_vld_reg   <= st_vld_next;
            if (thr_wr)
            begin
                thr_byp_valid_reg <= 1'b1;
            end
            if (st_wr)
            begin
                st_byp_valid_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg  <= s_axis_tuser[0];
            s1_skip_reg  <= s_axis_tuser[1];
            s1_hit_reg   <= in_hit;
            s1_rule_reg  <= in_rule;
            s1_addr_reg  <= in_addr;
            s1_value_reg <= s_axis_tdata[3 +: VW];
            s1_load_reg  <= s_axis_tdata[3+VW +: THR_W];
        end
        if (thr_wr)
        begin
            thr_byp_addr_reg <= s1_addr_reg;
            thr_byp_data_reg <= s1_load_reg;
        end
        if (st_wr)
        begin
            st_byp_addr_reg <= s1_addr_reg;
            st_byp_data_reg <= st_wdata;
        end
        if (s1_fire && has_result)
        begin
            m_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Rule memories: read on input transfer, written from evaluation stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            thr_rd_reg <= thr_mem[in_addr];
        end
        if (thr_wr)
        begin
            thr_mem[s1_addr_reg] <= s1_load_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            st_rd_reg <= st_mem[in_addr];
        end
        if (st_wr)
        begin
            st_mem[s1_addr_reg] <= st_wdata;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[rtl/mlta_checker.sv]
// Port-level checker for the threshold alarm, bound to the top level.
`include "multi_level_threshold_alarm_top_defines.svh"

module mlta_checker
    import mlta_pkg::*;
#(
    parameter int RULE_COUNT  = 8,
    parameter int VALUE_WIDTH = 32
)(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [((2*VALUE_WIDTH+6+7)/8)*8-1:0]   m_axis_tdata
);

    // stalled result holds
    `MLTA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // a clear transfer always reports level zero
    `MLTA_ASSERT_NOW(a_clear_level, m_axis_tvalid && !m_axis_tdata[OUT_ACTIVE_BIT], m_axis_tdata[OUT_LEVEL_LSB +: 2] == LVL_CLEAR, "clear alert with nonzero level")

    // a raised alert never reports level zero
    `MLTA_ASSERT_NOW(a_raise_level, m_axis_tvalid && m_axis_tdata[OUT_ACTIVE_BIT], m_axis_tdata[OUT_LEVEL_LSB +: 2] != LVL_CLEAR, "raised alert with level zero")

    // only configured rules produce alerts
    `MLTA_ASSERT_NOW(a_rule_range, m_axis_tvalid, 32'(m_axis_tdata[OUT_RULE_LSB +: 3]) < RULE_COUNT, "alert for a rule beyond the table")

endmodule

bind multi_level_threshold_alarm_top mlta_checker #(
    .RULE_COUNT  (RULE_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mlta_checker (.*);

[tb/tb_multi_level_threshold_alarm_top.sv]
// Self-checking stream testbench for the multi-level threshold alarm with debounce.
module tb_multi_level_threshold_alarm_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlta_pkg::*;

    localparam int VW             = 32;
    localparam int RULES          = 8;
    localparam int IN_W           = ((4*VW+4+7)/8)*8;
    localparam int OUT_W          = ((2*VW+6+7)/8)*8;
    localparam int ONE            = 65536;          // 1.0 in Q16.16
    localparam int WATCHDOG_LIMIT = 2000;           // quiet cycles before giving up
    localparam int DRAIN_CYCLES   = 8;              // wait for stragglers after the last expected alert

    localparam logic signed [VW-1:0] VAL_LO = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VAL_HI = {1'b0, {(VW-1){1'b1}}};

    // One input item as the stream carries it.
    typedef struct packed {
        logic                 mode;
        logic [2:0]           rule;
        logic signed [VW-1:0] value;
        logic signed [VW-1:0] warn;
        logic signed [VW-1:0] crit;
        logic signed [VW-1:0] emerg;
        logic                 upper;
        logic                 skip;
    } alarm_item_t;

    // One alert on the result stream.
    typedef struct packed {
        logic [2:0]           rule;
        level_t               level;
        logic                 active;
        logic signed [VW-1:0] value;
        logic signed [VW-1:0] thr;
    } alert_t;

    // Row of the directed table; fixed rows carry a hand-written alert.
    typedef struct packed {
        alarm_item_t item;
        logic        fixed;
        alert_t      want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // DUT signals, the driven ones known from time zero
    // ------------------------------------------------------------------
    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [7:0]       cfg_wr_data   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // tdata: rule_index[2:0], sample_value, warn_limit, crit_limit, emerg_limit,
    //        side select, zero pad
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    // tuser: mode, skip
    logic [1:0]       s_axis_tuser  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // tdata: alert_rule[2:0], alert_level[1:0], alert_active, alert_value,
    //        alert_threshold, zero pad
    logic [OUT_W-1:0] m_axis_tdata;

    multi_level_threshold_alarm_top #(
        .RULE_COUNT (RULES),
        .VALUE_WIDTH(VW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Rule table mirror: thresholds, side, level and debounce count per rule
    // ------------------------------------------------------------------
    logic signed [VW-1:0] warn_tab  [RULES];
    logic signed [VW-1:0] crit_tab  [RULES];
    logic signed [VW-1:0] emerg_tab [RULES];
    logic                 side_tab  [RULES];
    level_t               level_tab [RULES];
    logic [7:0]           count_tab [RULES];
    bit                   loaded_tab[RULES];
    logic [7:0]           debounce_len = DEBOUNCE_RESET;

    alert_t alerts_due[$];      // alerts predicted but not yet seen on m_axis
    plan_row_t directed_plan[$];

    // Tags that travel with the item on the bus so the monitor knows
    // whether the current row has a hand-written alert.
    logic   row_fixed = 1'b0;
    alert_t row_want  = '0;

    int errors         = 0;
    int items_taken    = 0;
    int alerts_raised  = 0;
    int alerts_cleared = 0;
    int quiet_cycles   = 0;
    string debounce_log = "3";

    // Idle shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Random stream state: bursts of items on one rule
    logic [2:0] focus_rule = '0;
    int         burst_left = 0;
    bit         burst_hot  = 0;

    initial
    begin
        for (int r = 0; r < RULES; r++)
        begin
            level_tab[r]  = LVL_CLEAR;
            count_tab[r]  = '0;
            loaded_tab[r] = 0;
            warn_tab[r]   = '0;
            crit_tab[r]   = '0;
            emerg_tab[r]  = '0;
            side_tab[r]   = 1'b0;
        end
    end

    // Level of a value against one rule; exact signed compares.
    function automatic level_t level_for(input logic [2:0] r, input logic signed [VW-1:0] v);
        if (side_tab[r])
        begin
            if (v > emerg_tab[r]) return LVL_EMERG;
            if (v > crit_tab[r])  return LVL_CRIT;
            if (v > warn_tab[r])  return LVL_WARN;
        end
        else
        begin
            if (v < emerg_tab[r]) return LVL_EMERG;
            if (v < crit_tab[r])  return LVL_CRIT;
            if (v < warn_tab[r])  return LVL_WARN;
        end
        return LVL_CLEAR;
    endfunction

    // Applies one accepted item to the rule table; returns 1 with the alert
    // it raises or clears, 0 when the item gives no result.
    function automatic bit evaluate_rule(input alarm_item_t it, output alert_t a);
        level_t lv;
        a = '0;
        if (it.mode == MODE_LOAD)
        begin
            // a load always wins, skip or not, and never reports
            warn_tab[it.rule]   = it.warn;
            crit_tab[it.rule]   = it.crit;
            emerg_tab[it.rule]  = it.emerg;
            side_tab[it.rule]   = it.upper;
            level_tab[it.rule]  = LVL_CLEAR;
            count_tab[it.rule]  = '0;
            loaded_tab[it.rule] = 1;
            return 0;
        end
        if (it.skip)
            return 0;
        lv = level_for(it.rule, it.value);
        a.rule  = it.rule;
        a.value = it.value;
        if (lv != LVL_CLEAR)
        begin
            if (count_tab[it.rule] != COUNT_MAX)
                count_tab[it.rule] = count_tab[it.rule] + 8'd1;
            if (count_tab[it.rule] >= debounce_len && lv != level_tab[it.rule])
            begin
                level_tab[it.rule] = lv;
                a.level  = lv;
                a.active = 1'b1;
                a.thr    = (lv == LVL_EMERG) ? emerg_tab[it.rule] :
                           (lv == LVL_CRIT)  ? crit_tab[it.rule]  : warn_tab[it.rule];
                return 1;
            end
            return 0;
        end
        // back in range: the run of out-of-range samples is broken
        count_tab[it.rule] = '0;
        if (level_tab[it.rule] != LVL_CLEAR)
        begin
            level_tab[it.rule] = LVL_CLEAR;
            a.level  = LVL_CLEAR;
            a.active = 1'b0;
            a.thr    = warn_tab[it.rule];
            return 1;
        end
        return 0;
    endfunction

    function automatic logic signed [VW-1:0] clamp_val(input longint v);
        if (v > longint'(VAL_HI)) return VAL_HI;
        if (v < longint'(VAL_LO)) return VAL_LO;
        return v[VW-1:0];
    endfunction

    // Random item: mostly bursts of samples on one loaded rule with values
    // placed around its thresholds, some loads, some skips, some noise.
    function automatic alarm_item_t next_random_item();
        alarm_item_t it;
        longint      base, step1, step2, t, v;
        int          dir, pick, sel;
        it.mode  = MODE_SAMPLE;
        it.value = $urandom;
        it.warn  = $urandom;
        it.crit  = $urandom;
        it.emerg = $urandom;
        it.upper = 1'($urandom_range(0, 1));
        it.skip  = ($urandom_range(0, 99) < 8);
        if (burst_left == 0)
        begin
            focus_rule = 3'($urandom_range(0, RULES-1));
            burst_left = $urandom_range(1, 10);
            burst_hot  = ($urandom_range(0, 1) == 1);
        end
        burst_left--;
        it.rule = focus_rule;
        if (!loaded_tab[it.rule] || $urandom_range(0, 99) < 8)
        begin
            it.mode = MODE_LOAD;
            if ($urandom_range(0, 9) != 0)
            begin
                // ordered thresholds; narrow steps now and then to put
                // several boundaries next to each other
                base  = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
                step1 = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 3))
                                                    : longint'($urandom_range(1, 24'hFF_FFFF));
                step2 = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 3))
                                                    : longint'($urandom_range(1, 24'hFF_FFFF));
                dir      = it.upper ? 1 : -1;
                it.warn  = base[VW-1:0];
                it.crit  = clamp_val(base + dir * step1);
                it.emerg = clamp_val(base + dir * (step1 + step2));
            end
            return it;
        end
        dir  = side_tab[it.rule] ? 1 : -1;
        pick = (burst_hot && $urandom_range(0, 9) < 7) ? 2 : $urandom_range(0, 3);
        sel  = $urandom_range(0, 2);
        t    = (sel == 0) ? longint'(warn_tab[it.rule]) :
               (sel == 1) ? longint'(crit_tab[it.rule]) : longint'(emerg_tab[it.rule]);
        case (pick)
            0: v = t + longint'($urandom_range(0, 4)) - 2;                  // on a boundary
            1: v = longint'(warn_tab[it.rule]) - dir * longint'($urandom_range(1, 50*ONE));
            2: v = t + dir * longint'($urandom_range(1, 4096));             // past a threshold
            default: v = longint'($signed($urandom));
        endcase
        it.value = clamp_val(v);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers; those that drive the bus are entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic plan_load(input logic [2:0] r, input logic signed [VW-1:0] w, c, e,
                             input logic up, input logic sk);
        plan_row_t row;
        row = '0;
        row.item.mode  = MODE_LOAD;
        row.item.rule  = r;
        row.item.value = $urandom;
        row.item.warn  = w;
        row.item.crit  = c;
        row.item.emerg = e;
        row.item.upper = up;
        row.item.skip  = sk;
        directed_plan = {directed_plan, row};
    endtask

    task automatic plan_sample(input logic [2:0] r, input logic signed [VW-1:0] v,
                               input logic sk);
        plan_row_t row;
        row = '0;
        row.item.mode  = MODE_SAMPLE;
        row.item.rule  = r;
        row.item.value = v;
        row.item.warn  = $urandom;
        row.item.crit  = $urandom;
        row.item.emerg = $urandom;
        row.item.upper = 1'($urandom_range(0, 1));
        row.item.skip  = sk;
        directed_plan = {directed_plan, row};
    endtask

    // Sample whose alert is written out by hand.
    task automatic plan_alert(input logic [2:0] r, input logic signed [VW-1:0] v,
                              input level_t lv, input logic act,
                              input logic signed [VW-1:0] thr);
        plan_sample(r, v, 1'b0);
        directed_plan[$].fixed       = 1'b1;
        directed_plan[$].want.rule   = r;
        directed_plan[$].want.level  = lv;
        directed_plan[$].want.active = act;
        directed_plan[$].want.value  = v;
        directed_plan[$].want.thr    = thr;
    endtask

    task automatic send_item(input alarm_item_t it, input logic fixed, input alert_t want);
        int               gap;
        logic [IN_W-1:0]  word;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word = '0;
        word[4*VW+3:0] = {it.upper, it.emerg, it.crit, it.warn, it.value, it.rule};
        s_axis_tdata  <= word;
        s_axis_tuser  <= {it.skip, it.mode};
        s_axis_tvalid <= 1'b1;
        row_fixed     <= fixed;
        row_want      <= want;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Register write only once the pipe has drained.
    task automatic set_debounce(input logic [7:0] len);
        s_axis_tvalid <= 1'b0;
        while (alerts_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge clk);
        cfg_wr_en    <= 1'b0;
        debounce_len  = len;
        debounce_log  = {debounce_log, $sformatf(" %0d", len)};
    endtask

    task automatic run_random(input int n);
        alarm_item_t it;
        int          counted;
        counted = 0;
        while (counted < n)
        begin
            it = next_random_item();
            send_item(it, 1'b0, '0);
            // skipped samples do nothing and are not counted
            if (!(it.mode == MODE_SAMPLE && it.skip))
                counted++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result side back-pressure
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each input transfer, then check each output
    // transfer against the oldest alert due. Prediction comes first so a
    // same-edge answer would still find its entry.
    // ------------------------------------------------------------------
    task automatic report_field(input string name, input longint want, input longint seen);
        errors++;
        $display("%0t: alert %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    endtask

    always @(posedge clk)
    begin
        alarm_item_t it;
        alert_t      pred, seen, want;
        bit          fires;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.rule  = s_axis_tdata[2:0];
                it.value = s_axis_tdata[3 +: VW];
                it.warn  = s_axis_tdata[3+VW +: VW];
                it.crit  = s_axis_tdata[3+2*VW +: VW];
                it.emerg = s_axis_tdata[3+3*VW +: VW];
                it.upper = s_axis_tdata[3+4*VW];
                it.mode  = s_axis_tuser[0];
                it.skip  = s_axis_tuser[1];
                fires = evaluate_rule(it, pred);
                if (row_fixed)
                    alerts_due = {alerts_due, row_want};
                else if (fires)
                    alerts_due = {alerts_due, pred};
                items_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen.rule   = m_axis_tdata[OUT_RULE_LSB +: 3];
                seen.level  = level_t'(m_axis_tdata[OUT_LEVEL_LSB +: 2]);
                seen.active = m_axis_tdata[OUT_ACTIVE_BIT];
                seen.value  = m_axis_tdata[OUT_VALUE_LSB +: VW];
                seen.thr    = m_axis_tdata[OUT_VALUE_LSB+VW +: VW];
                if (seen.active)
                    alerts_raised++;
                else
                    alerts_cleared++;
                if (alerts_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected alert, expected none, actual rule %0d level %0d",
                             $time, seen.rule, seen.level);
                    $display("    active %0b value %0d threshold %0d",
                             seen.active, seen.value, seen.thr);
                end
                else
                begin
                    want = alerts_due.pop_front();
                    if (seen.rule != want.rule)     report_field("rule", want.rule, seen.rule);
                    if (seen.level != want.level)   report_field("level", want.level, seen.level);
                    if (seen.active != want.active)
                        report_field("active", want.active, seen.active);
                    if (seen.value != want.value)   report_field("value", want.value, seen.value);
                    if (seen.thr != want.thr)       report_field("threshold", want.thr, seen.thr);
                end
            end
            // watchdog: nothing moving on either side for too long
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d alerts outstanding",
                         $time, WATCHDOG_LIMIT, alerts_due.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        alarm_item_t it;
        int          lvl;

        // Directed table, run with the reset debounce length of 3.
        // rule 0: upper side at 100 / 150 / 200
        plan_load(3'd0, 100*ONE, 150*ONE, 200*ONE, 1'b1, 1'b0);
        // rule 7: lower side, emergency just above the most negative value
        plan_load(3'd7, -10*ONE, -20*ONE, VAL_LO + 1, 1'b0, 1'b0);
        // rule 3: thresholds at the extremes; skip on a load is ignored
        plan_load(3'd3, VAL_LO, 0, VAL_HI - 1, 1'b1, 1'b1);
        plan_sample(3'd0, 50*ONE, 1'b0);                        // in range, nothing
        plan_sample(3'd0, 160*ONE, 1'b0);                       // critical, count 1
        plan_sample(3'd0, 160*ONE, 1'b1);                       // skipped sample
        plan_sample(3'd0, 210*ONE, 1'b0);                       // emergency, count 2
        plan_alert(3'd0, 101*ONE, LVL_WARN, 1'b1, 100*ONE);     // count reaches 3
        plan_alert(3'd0, VAL_HI, LVL_EMERG, 1'b1, 200*ONE);
        plan_alert(3'd0, 100*ONE, LVL_CLEAR, 1'b0, 100*ONE);    // equal is in range
        plan_sample(3'd0, 100*ONE, 1'b0);                       // already clear
        plan_sample(3'd7, VAL_LO, 1'b0);
        plan_sample(3'd7, VAL_LO, 1'b0);
        plan_alert(3'd7, VAL_LO, LVL_EMERG, 1'b1, VAL_LO + 1);
        plan_alert(3'd7, -15*ONE, LVL_WARN, 1'b1, -10*ONE);     // lower level still alerts
        plan_alert(3'd7, VAL_HI, LVL_CLEAR, 1'b0, -10*ONE);
        plan_sample(3'd3, VAL_LO, 1'b0);                        // not above the minimum
        plan_sample(3'd3, VAL_HI, 1'b0);
        plan_sample(3'd3, 0, 1'b0);
        plan_alert(3'd3, 1, LVL_CRIT, 1'b1, 0);
        plan_load(3'd3, VAL_LO, 0, VAL_HI - 1, 1'b1, 1'b0);     // reload drops the level
        plan_sample(3'd3, VAL_LO, 1'b0);                        // so no clear here
        plan_sample(3'd3, VAL_HI, 1'b1);

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
            send_item(directed_plan[i].item, directed_plan[i].fixed, directed_plan[i].want);

        // Phase: no idling, alert on the first out-of-range sample
        set_debounce(8'd0);
        run_random(35);

        // Phase: sender idles most cycles
        send_idle_pct = 68;
        set_debounce(8'd1);
        run_random(35);

        // Phase: receiver stalls; longest debounce and count saturation.
        // Rule 2 sees a long unbroken run of raised samples so the count
        // pins at its maximum, then every level change still reports.
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        set_debounce(8'd255);
        it = '0;
        it.mode  = MODE_LOAD;
        it.rule  = 3'd2;
        it.value = $urandom;
        it.warn  = 10*ONE;
        it.crit  = 20*ONE;
        it.emerg = 30*ONE;
        it.upper = 1'b1;
        send_item(it, 1'b0, '0);
        for (int k = 0; k < 274; k++)
        begin
            lvl      = $urandom_range(1, 3);
            it.mode  = MODE_SAMPLE;
            it.warn  = $urandom;
            it.crit  = $urandom;
            it.emerg = $urandom;
            it.upper = 1'($urandom_range(0, 1));
            // last four: one back in range, then a fresh run too short to alert
            if (k == 270)
                it.value = 0;
            else
                it.value = lvl * 10 * ONE + $urandom_range(1, 9*ONE);
            send_item(it, 1'b0, '0);
        end

        set_debounce(8'($urandom_range(2, 6)));
        run_random(35);

        // Phase: both sides idle now and then
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        set_debounce(8'($urandom_range(0, 4)));
        run_random(35);

        // Drain: all expected alerts in, then a wait for stragglers
        s_axis_tvalid <= 1'b0;
        while (alerts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d items, %0d alerts raised and %0d cleared", items_taken,
                 alerts_raised, alerts_cleared);
        $display("Debounce lengths used: %s; count saturation on rule 2", debounce_log);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
